[src/annexb_nal_unit_extractor_unit_assert.svh]
// Assertion macros shared by the NAL unit extractor RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ANNEXB_NAL_UNIT_EXTRACTOR_UNIT_ASSERT_SVH
`define ANNEXB_NAL_UNIT_EXTRACTOR_UNIT_ASSERT_SVH

// Checked on every rising edge outside reset
`define ANX_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every rising edge, reset included
`define ANX_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

[src/anx_pkg.sv]
// Shared types and constants for the Annex B NAL unit extractor.
// No dependencies; imported by every module of the block.
package anx_pkg;

   // Parser phase
   typedef enum logic [1:0] {
      PH_SEEK    = 2'd0,
      PH_UNIT    = 2'd1,
      PH_DISCARD = 2'd2
   } phase_type;

   // Byte values of interest in an Annex B stream
   localparam logic [7:0] ZERO_BYTE  = 8'h00;
   localparam logic [7:0] START_BYTE = 8'h01;
   localparam logic [7:0] EPB_BYTE   = 8'h03;

   // Bit positions in rsp_tuser
   localparam int USER_HAS_BYTE  = 0;
   localparam int USER_UNIT_END  = 1;
   localparam int USER_BAD_START = 2;
   localparam int USER_W         = 3;

   // Work descriptor for one input byte: results are emitted in the order
   // held zeros, payload byte, then end-of-unit marks or the error mark.
   typedef struct packed {
      logic [1:0] zeros;
      logic       has_byte;
      logic [7:0] data;
      logic [1:0] ends;
      logic       bad;
   } desc_type;

   // Descriptor queue status
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

[src/annexb_nal_unit_extractor_unit.sv]
// Top level of the Annex B NAL unit extractor.
// Depends on anx_pkg, anx_front, anx_desc_fifo and anx_back.
//
// Parses an Annex B byte stream arriving one byte per req transaction
// (req_tlast on the final byte of the stream) and returns NAL unit payload with
// emulation prevention bytes removed, a unit_end transaction after each unit,
// and a single bad_start transaction if the stream does not open with a valid
// start code, or if the zero run that ends a unit is not followed by one (the
// rest of that stream is then dropped). One byte is accepted per cycle while
// the queue has room; each byte yields zero to four results, and results leave
// at one per cycle from the output register while rsp_tready is high, so a byte
// with several results (held zeros flushed together with a payload byte, or a
// closed unit) holds the result side until all of them have left. A
// QUEUE_DEPTH-entry descriptor queue absorbs such bursts; req_tready drops only
// when that queue is full. The last result of each input byte carries rsp_tlast.
module annexb_nal_unit_extractor_unit
   import anx_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] in_byte
   input  logic              req_tlast,   // end_of_stream
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // [7:0] out_byte
   output logic [USER_W-1:0] rsp_tuser,   // [0] has_byte, [1] unit_end, [2] bad_start
   output logic              rsp_tlast    // last_result
);

   qstat_type qstat;
   logic      push_valid;
   desc_type  push_desc;
   desc_type  head_desc;
   logic      pop;

   // Start-code tracking and descriptor build
   anx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .qstat      (qstat),
      .push_valid (push_valid),
      .push_desc  (push_desc)
   );

   // Descriptor queue
   anx_desc_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_desc  (push_desc),
      .pop        (pop),
      .head_desc  (head_desc),
      .qstat      (qstat)
   );

   // Result expansion and output register
   anx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_desc  (head_desc),
      .qstat      (qstat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[src/anx_front.sv]
// Front end: accepts stream bytes, tracks start-code state, builds descriptors.
// Depends on anx_pkg.
module anx_front
   import anx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // end_of_stream
   input  qstat_type  qstat,
   output logic       push_valid,
   output desc_type   push_desc
);

   phase_type  phase_ff, phase_in;
   logic [1:0] zrun_ff, zrun_in;
   logic       accept;
   logic       eos;
   logic [7:0] b;
   logic       zrun_sat;
   desc_type   desc;

   assign b          = req_tdata;
   assign eos        = req_tlast;
   assign zrun_sat   = zrun_ff[1];
   assign req_tready = !qstat.full;
   assign accept     = req_tvalid && req_tready;

   // Next phase and zero count
   always_comb begin
      phase_in = phase_ff;
      zrun_in  = zrun_ff;
      unique case (phase_ff)
         PH_SEEK: begin
            if (b == ZERO_BYTE) begin
               zrun_in = zrun_sat ? zrun_ff : zrun_ff + 2'd1;
            end else if (zrun_sat && b == START_BYTE) begin
               phase_in = PH_UNIT;
               zrun_in  = 2'd0;
            end else begin
               phase_in = PH_DISCARD;
               zrun_in  = 2'd0;
            end
         end
         PH_UNIT: begin
            if (zrun_sat) begin
               if (b == ZERO_BYTE) begin
                  phase_in = PH_SEEK;
                  zrun_in  = 2'd2;
               end else begin
                  zrun_in = 2'd0;
               end
            end else if (b == ZERO_BYTE && !eos) begin
               zrun_in = zrun_ff + 2'd1;
            end else begin
               zrun_in = 2'd0;
            end
         end
         default: ;
      endcase
      // stream end starts over
      if (eos) begin
         phase_in = PH_SEEK;
         zrun_in  = 2'd0;
      end
   end

   // Descriptor for the current byte
   always_comb begin
      desc = '0;
      unique case (phase_ff)
         PH_SEEK: begin
            if (b == ZERO_BYTE) begin
               desc = '0;
            end else if (zrun_sat && b == START_BYTE) begin
               desc.ends = {1'b0, eos};
            end else begin
               desc.bad = 1'b1;
            end
         end
         PH_UNIT: begin
            if (zrun_sat) begin
               if (b == ZERO_BYTE) begin
                  desc.ends = 2'd1;
               end else if (b == START_BYTE) begin
                  desc.ends = eos ? 2'd2 : 2'd1;
               end else begin
                  desc.zeros    = 2'd2;
                  desc.has_byte = (b != EPB_BYTE);
                  desc.data     = b;
                  desc.ends     = {1'b0, eos};
               end
            end else if (b == ZERO_BYTE && !eos) begin
               desc = '0;
            end else begin
               desc.zeros    = zrun_ff;
               desc.has_byte = 1'b1;
               desc.data     = b;
               desc.ends     = {1'b0, eos};
            end
         end
         default: ;
      endcase
   end

   // Only bytes that cause results enter the queue
   assign push_desc  = desc;
   assign push_valid = accept &&
      (desc.zeros != 2'd0 || desc.has_byte || desc.ends != 2'd0 || desc.bad);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEEK;
         zrun_ff  <= 2'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         zrun_ff  <= zrun_in;
      end
   end

endmodule

[src/anx_desc_fifo.sv]
// Descriptor queue between the front end and the result expander.
// Depends on anx_pkg and the assertion macro header.
`include "annexb_nal_unit_extractor_unit_assert.svh"

module anx_desc_fifo
   import anx_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  desc_type  push_desc,
   input  logic      pop,
   output desc_type  head_desc,
   output qstat_type qstat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   desc_type         queue_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             wr_en, rd_en;

   assign qstat.full  = (count_ff == FULL_CNT);
   assign qstat.empty = (count_ff == '0);
   assign wr_en       = push_valid && !qstat.full;
   assign rd_en       = pop && !qstat.empty;
   assign head_desc   = queue_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         queue_ff[wr_ptr_ff] <= push_desc;
      end
   end

   `ANX_ASSERT(a_fifo_count_range, count_ff <= FULL_CNT, "descriptor count beyond depth")
   `ANX_ASSERT(a_fifo_no_overflow, !(push_valid && qstat.full), "push into full queue")
   `ANX_ASSERT(a_fifo_no_underflow, !(pop && qstat.empty), "pop from empty queue")
   `ANX_ASSERT_ALWAYS(a_fifo_reset_empty, reset |=> count_ff == '0, "queue not empty after reset")

endmodule

[src/anx_back.sv]
// Back end: expands queued descriptors into results, one per cycle unless stalled.
// Depends on anx_pkg and the assertion macro header.
`include "annexb_nal_unit_extractor_unit_assert.svh"

module anx_back
   import anx_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  desc_type          head_desc,
   input  qstat_type         qstat,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,  // [7:0] out_byte
   output logic [USER_W-1:0] rsp_tuser,  // [0] has_byte, [1] unit_end, [2] bad_start
   output logic              rsp_tlast   // last_result
);

   logic [1:0]        step_ff, step_in;
   logic              valid_ff, valid_in;
   logic [7:0]        data_ff, data_in;
   logic [USER_W-1:0] user_ff, user_in;
   logic              last_ff, last_in;
   logic [2:0]        total;
   logic [2:0]        k;
   logic              load;

   assign total = 3'(head_desc.zeros) + 3'(head_desc.has_byte) + 3'(head_desc.ends)
                + 3'(head_desc.bad);
   assign k     = 3'(step_ff);
   assign load  = !qstat.empty && (!valid_ff || rsp_tready);
   assign pop   = load && last_in;

   // Result for the current step of the head descriptor
   always_comb begin
      data_in = ZERO_BYTE;
      user_in = '0;
      last_in = (k == total - 3'd1);
      priority if (k < 3'(head_desc.zeros)) begin
         user_in[USER_HAS_BYTE] = 1'b1;
      end else if (head_desc.has_byte && k == 3'(head_desc.zeros)) begin
         data_in                = head_desc.data;
         user_in[USER_HAS_BYTE] = 1'b1;
      end else if (head_desc.bad) begin
         user_in[USER_BAD_START] = 1'b1;
      end else begin
         user_in[USER_UNIT_END] = 1'b1;
      end
   end

   // Step counter and output valid
   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         step_in  = last_in ? 2'd0 : step_ff + 2'd1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
         user_ff <= user_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

   `ANX_ASSERT(a_back_one_kind, valid_ff |-> $onehot(user_ff), "result has no single kind")
   `ANX_ASSERT(a_back_byte_zero, (valid_ff && !user_ff[USER_HAS_BYTE]) |-> data_ff == ZERO_BYTE,
      "non-byte result carries data")
   `ANX_ASSERT(a_back_bad_last, (valid_ff && user_ff[USER_BAD_START]) |-> last_ff,
      "error result not last of its byte")
   `ANX_ASSERT(a_back_step_range, !qstat.empty |-> k < total, "step beyond descriptor")

endmodule
